@@ src/mersenne_twister_64_generator_assert.svh @@
// Assertion helpers, clocked on clk and disabled in reset.
`ifndef MERSENNE_TWISTER_64_GENERATOR_ASSERT_SVH
`define MERSENNE_TWISTER_64_GENERATOR_ASSERT_SVH

// prop must hold in every cycle in which cond holds
`define MT64_ASSERT_IMPLY(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// cond must never hold
`define MT64_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error(msg);

`endif

@@ src/mt64_pkg.sv @@
package mt64_pkg;

  localparam int N_WORDS         = 312;
  localparam int SHIFT_WORDS     = 156;
  localparam int ADDR_W          = $clog2(N_WORDS);
  localparam int WORD_W          = 64;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [WORD_W-1:0] MATRIX_A   = 64'hB502_6F5A_A966_19E9;
  localparam logic [WORD_W-1:0] UPPER_MASK = 64'hFFFF_FFFF_8000_0000;
  localparam logic [WORD_W-1:0] LOWER_MASK = 64'h0000_0000_7FFF_FFFF;
  localparam logic [WORD_W-1:0] TEMPER_D   = 64'h5555_5555_5555_5555;
  localparam logic [WORD_W-1:0] TEMPER_B   = 64'h71D6_7FFF_EDA6_0000;
  localparam logic [WORD_W-1:0] TEMPER_C   = 64'hFFF7_EEE0_0000_0000;

  typedef enum logic {
    REQ_LOAD = 1'b0,
    REQ_NEXT = 1'b1
  } req_kind_t;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_PRIME = 2'd1,
    OP_TWIST = 2'd2
  } op_t;

  typedef struct packed {
    req_kind_t           kind;
    logic                index_ok;
    logic [ADDR_W-1:0]   index;
    logic [WORD_W-1:0]   value;
  } item_t;

  function automatic logic [WORD_W-1:0] twist(input logic [WORD_W-1:0] cur,
                                               input logic [WORD_W-1:0] nbr,
                                               input logic [WORD_W-1:0] far);
    logic [WORD_W-1:0] y;
    y = (cur & UPPER_MASK) | (nbr & LOWER_MASK);
    return far ^ (y >> 1) ^ (y[0] ? MATRIX_A : '0);
  endfunction

  function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] x);
    logic [WORD_W-1:0] y;
    y = x;
    y = y ^ ((y >> 29) & TEMPER_D);
    y = y ^ ((y << 17) & TEMPER_B);
    y = y ^ ((y << 37) & TEMPER_C);
    y = y ^ (y >> 43);
    return y;
  endfunction

endpackage

@@ src/mt64_ram.sv @@
module mt64_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 312,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AddrW-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/mt64_front.sv @@
module mt64_front #(
  parameter int QUEUE_DEPTH = mt64_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        req_type,
  input  logic [mt64_pkg::ADDR_W-1:0] word_index,
  input  logic [mt64_pkg::WORD_W-1:0] word_value,
  output logic                        head_valid,
  output mt64_pkg::item_t             head,
  input  logic                        head_ready
);

  import mt64_pkg::*;

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  item_t            q [QUEUE_DEPTH];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [CntW-1:0]  count;
  logic             push;
  logic             pop;
  item_t            in_item;

  always_comb begin
    in_item.kind     = req_kind_t'(req_type);
    in_item.index_ok = (word_index < ADDR_W'(N_WORDS));
    in_item.index    = word_index;
    in_item.value    = word_value;
  end

  assign in_ready   = (count != CntW'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = q[rd_ptr];
  assign push       = in_valid && in_ready;
  assign pop        = head_valid && head_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ src/mt64_back.sv @@
`include "mersenne_twister_64_generator_assert.svh"

module mt64_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        head_valid,
  input  mt64_pkg::item_t             head,
  output logic                        head_ready,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [mt64_pkg::WORD_W-1:0] random_value
);

  import mt64_pkg::*;

  // issue stage
  logic [ADDR_W-1:0] pos;
  logic              primed;
  logic [ADDR_W-1:0] nb;
  logic [ADDR_W-1:0] far;
  op_t               issue_op;
  logic              hazard;
  logic              issue;

  // execute stage
  logic              s2_valid;
  op_t               s2_op;
  logic              s2_wen;
  logic [ADDR_W-1:0] s2_addr;
  logic [WORD_W-1:0] s2_value;
  logic              s2_advance;
  logic              s2_free;
  logic [WORD_W-1:0] cur;
  logic [WORD_W-1:0] twisted;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic              ra_re;
  logic [ADDR_W-1:0] ra_addr;
  logic [WORD_W-1:0] ra_data;
  logic              rb_re;
  logic [WORD_W-1:0] rb_data;

  assign nb  = (pos == ADDR_W'(N_WORDS - 1)) ? '0 : ADDR_W'(pos + 1'b1);
  assign far = (pos >= ADDR_W'(SHIFT_WORDS)) ? ADDR_W'(pos - ADDR_W'(SHIFT_WORDS))
                                             : ADDR_W'(pos + ADDR_W'(SHIFT_WORDS));

  always_comb begin
    if (head.kind == REQ_LOAD) begin
      issue_op = OP_LOAD;
    end else if (primed) begin
      issue_op = OP_TWIST;
    end else begin
      issue_op = OP_PRIME;
    end
  end

  // word 0 must not be fetched while the last load is still being written
  assign hazard     = (issue_op == OP_PRIME) && s2_valid && (s2_op == OP_LOAD);
  assign s2_advance = s2_valid && ((s2_op != OP_TWIST) || !out_valid || out_ready);
  assign s2_free    = !s2_valid || s2_advance;
  assign issue      = head_valid && s2_free && !hazard;
  assign head_ready = issue && (issue_op != OP_PRIME);

  assign ra_re   = issue && (issue_op != OP_LOAD);
  assign ra_addr = (issue_op == OP_PRIME) ? pos : nb;
  assign rb_re   = issue && (issue_op == OP_TWIST);

  always_ff @(posedge clk) begin
    if (rst) begin
      pos    <= '0;
      primed <= 1'b0;
    end else if (issue) begin
      unique case (issue_op)
        OP_LOAD: begin
          pos    <= '0;
          primed <= 1'b0;
        end
        OP_PRIME: primed <= 1'b1;
        OP_TWIST: pos    <= nb;
        default:  pos    <= pos;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_free) begin
      s2_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_free && issue) begin
      s2_op    <= issue_op;
      s2_value <= head.value;
      unique case (issue_op)
        OP_LOAD: begin
          s2_addr <= head.index;
          s2_wen  <= head.index_ok;
        end
        OP_TWIST: begin
          s2_addr <= pos;
          s2_wen  <= 1'b1;
        end
        default: begin
          s2_addr <= pos;
          s2_wen  <= 1'b0;
        end
      endcase
    end
  end

  assign twisted   = twist(cur, ra_data, rb_data);
  assign ram_we    = s2_advance && s2_wen;
  assign ram_waddr = s2_addr;
  assign ram_wdata = (s2_op == OP_LOAD) ? s2_value : twisted;

  // cur holds the untwisted word at the current position
  always_ff @(posedge clk) begin
    if (s2_advance && (s2_op != OP_LOAD)) begin
      cur <= ra_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_advance && (s2_op == OP_TWIST)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_advance && (s2_op == OP_TWIST)) begin
      random_value <= temper(twisted);
    end
  end

  // copy a: current and neighbor words; copy b: word half the state away
  mt64_ram #(
    .WIDTH (WORD_W),
    .DEPTH (N_WORDS)
  ) u_ram_a (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ra_re),
    .raddr (ra_addr),
    .rdata (ra_data)
  );

  mt64_ram #(
    .WIDTH (WORD_W),
    .DEPTH (N_WORDS)
  ) u_ram_b (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (rb_re),
    .raddr (far),
    .rdata (rb_data)
  );

  `MT64_ASSERT_NEVER(a_pos_range, pos >= ADDR_W'(N_WORDS), "word position out of range")
  `MT64_ASSERT_IMPLY(a_twist_primed, issue && (issue_op == OP_TWIST), primed, "twist without word 0")
  `MT64_ASSERT_IMPLY(a_prime_order, issue && (issue_op == OP_PRIME), !(s2_valid && (s2_op == OP_LOAD)), "prime read races load write")
  `MT64_ASSERT_IMPLY(a_wr_range, ram_we, ram_waddr < ADDR_W'(N_WORDS), "state write out of range")

endmodule

@@ src/mersenne_twister_64_generator.sv @@
// 64-bit Mersenne Twister (mt19937_64) with word-by-word state loading. A beat
// with req_type 0 writes word_value into state word word_index (indexes 312
// and up write nothing) and restarts the sequence at word 0; a beat with
// req_type 1 twists the word at the current position and returns it tempered
// on random_value. Sustained rate is one number per clock while out_ready
// holds high: the twist engine reads the neighbor word and the word 156 places
// away from two copies of the state RAM each cycle and writes the new word
// back from the execute stage. The first request after loads fetches word 0
// first, a read that waits while the last load is still in the execute stage.
// A result passes through the input queue, RAM read and output register. The
// state RAM is not cleared after reset; load all 312 words before requesting.
module mersenne_twister_64_generator #(
  parameter int QUEUE_DEPTH = mt64_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        req_type,
  input  logic [mt64_pkg::ADDR_W-1:0] word_index,
  input  logic [mt64_pkg::WORD_W-1:0] word_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [mt64_pkg::WORD_W-1:0] random_value
);

  import mt64_pkg::*;

  logic  head_valid;
  logic  head_ready;
  item_t head;

  mt64_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .word_index (word_index),
    .word_value (word_value),
    .head_valid (head_valid),
    .head       (head),
    .head_ready (head_ready)
  );

  mt64_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head         (head),
    .head_ready   (head_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .random_value (random_value)
  );

endmodule

@@ tb/mersenne_twister_64_generator_tb.sv @@
module mersenne_twister_64_generator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mt64_pkg::ADDR_W;
  import mt64_pkg::WORD_W;
  import mt64_pkg::req_kind_t;
  import mt64_pkg::REQ_LOAD;
  import mt64_pkg::REQ_NEXT;

  localparam int unsigned STATE_WORDS = 312;
  localparam int unsigned FAR_OFFSET  = 156;
  localparam logic [WORD_W-1:0] TWIST_XOR = 64'hB502_6F5A_A966_19E9;
  localparam logic [WORD_W-1:0] HI_MASK   = 64'hFFFF_FFFF_8000_0000;
  localparam logic [WORD_W-1:0] LO_MASK   = 64'h0000_0000_7FFF_FFFF;
  localparam logic [WORD_W-1:0] SHAPE_D   = 64'h5555_5555_5555_5555;
  localparam logic [WORD_W-1:0] SHAPE_B   = 64'h71D6_7FFF_EDA6_0000;
  localparam logic [WORD_W-1:0] SHAPE_C   = 64'hFFF7_EEE0_0000_0000;
  localparam logic [WORD_W-1:0] ONES      = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam int N_ROWS = 18;
  localparam int RANDOM_BEATS = 880;
  localparam int HOLD_CYCLES = 300;

  typedef struct {
    req_kind_t          kind;
    logic [ADDR_W-1:0]  idx;
    logic [WORD_W-1:0]  val;
    bit                 typed;
    logic [WORD_W-1:0]  want;
  } stim_row_t;

  typedef struct {
    logic [WORD_W-1:0] predicted;
    bit                typed;
    logic [WORD_W-1:0] typed_val;
  } number_expect_t;

  typedef enum {RX_STEADY, RX_COIN, RX_TOGGLE, RX_STALL} rx_mode_t;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic req_type;
  logic [ADDR_W-1:0] word_index;
  logic [WORD_W-1:0] word_value;
  logic out_valid;
  logic out_ready;
  logic [WORD_W-1:0] random_value;

  // expectation tag that travels with a directed beat
  bit row_typed;
  logic [WORD_W-1:0] row_expect;

  logic [WORD_W-1:0] gen_words [STATE_WORDS];
  int unsigned gen_pos;
  number_expect_t pending_numbers [$];

  int errors;
  int loads_seen;
  int oob_loads;
  int requests_seen;
  int numbers_checked;
  int wraps_seen;
  int burst_left;
  bit hold_request;
  bit hold_done;

  stim_row_t directed_rows [N_ROWS] = '{
    '{REQ_NEXT, 9'd0,   64'd0,                  1'b1, 64'd0},
    '{REQ_NEXT, 9'd0,   64'd0,                  1'b1, 64'd0},
    '{REQ_LOAD, 9'd312, ONES,                   1'b0, 64'd0},
    '{REQ_LOAD, 9'd511, ONES,                   1'b0, 64'd0},
    '{REQ_NEXT, 9'd511, ONES,                   1'b1, 64'd0},
    '{REQ_LOAD, 9'd0,   ONES,                   1'b0, 64'd0},
    '{REQ_LOAD, 9'd1,   ONES,                   1'b0, 64'd0},
    '{REQ_LOAD, 9'd156, 64'd0,                  1'b0, 64'd0},
    '{REQ_NEXT, 9'd0,   64'd0,                  1'b0, 64'd0},
    '{REQ_NEXT, 9'd0,   64'd0,                  1'b0, 64'd0},
    '{REQ_LOAD, 9'd311, 64'h8000_0000_0000_0000, 1'b0, 64'd0},
    '{REQ_LOAD, 9'd155, ONES,                   1'b0, 64'd0},
    '{REQ_LOAD, 9'd2,   64'h0000_0000_0000_0001, 1'b0, 64'd0},
    '{REQ_LOAD, 9'd157, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 64'd0},
    '{REQ_NEXT, 9'd0,   64'd0,                  1'b0, 64'd0},
    '{REQ_NEXT, 9'd0,   64'd0,                  1'b0, 64'd0},
    '{REQ_LOAD, 9'd200, 64'h5555_5555_5555_5555, 1'b0, 64'd0},
    '{REQ_NEXT, 9'd0,   64'd0,                  1'b0, 64'd0}
  };

  mersenne_twister_64_generator DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .req_type     (req_type),
    .word_index   (word_index),
    .word_value   (word_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .random_value (random_value)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [WORD_W-1:0] advance_generator();
    int unsigned p;
    int unsigned nb;
    int unsigned far_i;
    logic [WORD_W-1:0] y;
    logic [WORD_W-1:0] w;
    p = (gen_pos < STATE_WORDS) ? gen_pos : 0;
    nb = (p + 1 >= STATE_WORDS) ? p + 1 - STATE_WORDS : p + 1;
    far_i = (p + FAR_OFFSET >= STATE_WORDS) ? p + FAR_OFFSET - STATE_WORDS : p + FAR_OFFSET;
    y = (gen_words[p] & HI_MASK) | (gen_words[nb] & LO_MASK);
    w = gen_words[far_i] ^ (y >> 1) ^ (y[0] ? TWIST_XOR : 64'd0);
    gen_words[p] = w;
    gen_pos = nb;
    if (nb == 0) wraps_seen++;
    y = w;
    y = y ^ ((y >> 29) & SHAPE_D);
    y = y ^ ((y << 17) & SHAPE_B);
    y = y ^ ((y << 37) & SHAPE_C);
    y = y ^ (y >> 43);
    return y;
  endfunction

  function automatic logic [WORD_W-1:0] rand_word();
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) return '0;
    if (pick == 1) return ONES;
    return {$urandom, $urandom};
  endfunction

  task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                 input logic [WORD_W-1:0] want);
    $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $time);
    errors++;
  endtask

  task automatic send_beat(input req_kind_t kind, input logic [ADDR_W-1:0] idx,
                           input logic [WORD_W-1:0] val, input bit typed,
                           input logic [WORD_W-1:0] want);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 20);
    end
    burst_left--;
    in_valid   <= 1'b1;
    req_type   <= kind;
    word_index <= idx;
    word_value <= val;
    row_typed  <= typed;
    row_expect <= want;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // scoreboard: check results first, then fold accepted beats into the predictor
  always @(posedge clk) begin : scoreboard
    number_expect_t e;
    logic [WORD_W-1:0] want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (pending_numbers.size() == 0) begin
          report_mismatch("unexpected number", random_value, '0);
        end else begin
          e = pending_numbers.pop_front();
          want = e.typed ? e.typed_val : e.predicted;
          if (random_value !== want) report_mismatch("random_value", random_value, want);
          numbers_checked++;
        end
      end
      if (in_valid && in_ready) begin
        if (req_type == REQ_NEXT) begin
          e.predicted = advance_generator();
          e.typed = row_typed;
          e.typed_val = row_expect;
          pending_numbers.push_back(e);
          requests_seen++;
        end else begin
          if (word_index < STATE_WORDS) gen_words[word_index] = word_value;
          else oob_loads++;
          gen_pos = 0;
          loads_seen++;
        end
      end
    end
  end

  initial begin : receiver
    rx_mode_t mode;
    int len;
    out_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_request && !hold_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end
      mode = rx_mode_t'($urandom_range(0, 3));
      len = $urandom_range(20, 80);
      case (mode)
        RX_STEADY: begin
          repeat (len) begin
            out_ready <= 1'b1;
            @(posedge clk);
          end
        end
        RX_COIN: begin
          repeat (len) begin
            out_ready <= 1'($urandom_range(0, 1));
            @(posedge clk);
          end
        end
        RX_TOGGLE: begin
          repeat (len) begin
            out_ready <= ~out_ready;
            @(posedge clk);
          end
        end
        default: begin
          out_ready <= 1'b0;
          repeat ($urandom_range(1, 12)) @(posedge clk);
        end
      endcase
    end
  end

  initial begin : stimulus
    int random_beats;
    int pick;
    int run_len;
    foreach (gen_words[i]) gen_words[i] = '0;
    gen_pos = 0;
    rst        <= 1'b1;
    in_valid   <= 1'b0;
    req_type   <= REQ_LOAD;
    word_index <= '0;
    word_value <= '0;
    row_typed  <= 1'b0;
    row_expect <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // all-zero state first: numbers drawn before any nonzero load come out zero
    for (int i = 0; i < STATE_WORDS; i++) send_beat(REQ_LOAD, ADDR_W'(i), '0, 1'b0, '0);
    foreach (directed_rows[i])
      send_beat(directed_rows[i].kind, directed_rows[i].idx, directed_rows[i].val,
                directed_rows[i].typed, directed_rows[i].want);

    random_beats = 0;
    for (int i = 0; i < STATE_WORDS; i++) begin
      send_beat(REQ_LOAD, ADDR_W'(i), rand_word(), 1'b0, '0);
      random_beats++;
    end
    hold_request = 1'b1;
    repeat (330) begin
      send_beat(REQ_NEXT, ADDR_W'($urandom_range(0, 511)), rand_word(), 1'b0, '0);
      random_beats++;
    end
    while (random_beats < RANDOM_BEATS) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(300, 340) : $urandom_range(1, 40);
        repeat (run_len) begin
          send_beat(REQ_NEXT, ADDR_W'($urandom_range(0, 511)), rand_word(), 1'b0, '0);
          random_beats++;
        end
      end else if (pick < 90) begin
        repeat ($urandom_range(1, 4)) begin
          send_beat(REQ_LOAD, ADDR_W'($urandom_range(0, STATE_WORDS - 1)), rand_word(),
                    1'b0, '0);
          random_beats++;
        end
      end else begin
        send_beat(REQ_LOAD, ADDR_W'($urandom_range(STATE_WORDS, 511)), rand_word(), 1'b0, '0);
        random_beats++;
      end
    end
    in_valid <= 1'b0;
    @(posedge clk);

    while (pending_numbers.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("%0d loads (%0d out of range) and %0d number requests, %0d numbers checked",
             loads_seen, oob_loads, requests_seen, numbers_checked);
    $display("position wrapped %0d times; long output hold %s", wraps_seen,
             hold_done ? "applied" : "missed");
    if (errors == 0) begin
      $display("mersenne_twister_64_generator_tb: clean");
    end else begin
      $display("mersenne_twister_64_generator_tb: errors");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("timeout at %0t", $time);
    $display("mersenne_twister_64_generator_tb: errors");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+src
src/mt64_pkg.sv
src/mt64_ram.sv
src/mt64_front.sv
src/mt64_back.sv
src/mersenne_twister_64_generator.sv
tb/mersenne_twister_64_generator_tb.sv
